// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the checker files
// no dependencies; include guard keeps it single
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under an active-low reset
`define AST_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication under an active-low reset
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/atcs_pkg.sv =====
// shared types, widths and constants of the aging top-k capture scheduler
// no dependencies; used by every module through scoped names

package atcs_pkg;

    localparam int MaxSlots         = 16;
    localparam int NeverCapturedAge = 1000;

    localparam int SlotW    = 4;
    localparam int PrioW    = 16;
    localparam int AgeW     = 10;
    localparam int AgeSat   = 1023;
    localparam int FacW     = 18;
    localparam int FacOne   = 16;
    localparam int UKeyW    = 34;
    localparam int PKeyW    = 24;
    localparam int GainW    = 8;
    localparam int GainShift = 6;
    localparam int CntW     = 5;
    localparam int FrameW   = 32;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 8;

    localparam logic [CntW-1:0]     BudgetRst = 5'd1;
    localparam logic [CntW-1:0]     LimitRst  = 5'd3;
    localparam logic [CfgDataW-1:0] WeightRst = 8'd8;
    localparam logic [CfgDataW-1:0] GainRst   = 8'd96;
    localparam logic [CfgDataW-1:0] WarmupRst = 8'd2;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_CAPTURE_BUDGET,
        CFG_ACTIVE_LIMIT,
        CFG_AGING_WEIGHT,
        CFG_HYSTERESIS_GAIN,
        CFG_WARMUP_FRAMES
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AGE,
        ST_FAC,
        ST_UKEY,
        ST_PKEY,
        ST_RANK_CAP,
        ST_RANK_ACT,
        ST_COMMIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic            start;
        logic [CntW-1:0] k;
    } rank_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rank_stat_t;

endpackage

// ===== rtl/core/aging_topk_capture_scheduler_unit.sv =====
// top level of the aging top-k capture scheduler
// depends on atcs_pkg and atcs_rank (shared top-k selector)
//
//  channel   ports                                         handshake
//  --------  --------------------------------------------  -------------------
//  input     s_action s_slot s_priority_req s_frame_end    s_valid / s_ready
//  result    m_out_slot m_capture m_active m_last_decision m_valid / m_ready
//  config    cfg_index cfg_wdata                           cfg_wr_en, no wait
//
//  an item without frame end leaves the unit idle; s_ready stays high
//  a frame end runs the key build (age, factor, usage key and priority key states
//  per slot) on the shared multiplier, two top-k runs, a commit state and an
//  emit walk over all slots; warmup skips build and ranking
//  the emit walk waits on m_ready; the last result may still sit in the
//  output register while the next item is taken; reset is synchronous, active low

module aging_topk_capture_scheduler_unit #(
    parameter int MAX_SLOTS = atcs_pkg::MaxSlots
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [atcs_pkg::SlotW-1:0]    s_slot,
    input  logic [atcs_pkg::PrioW-1:0]    s_priority_req,
    input  logic                          s_frame_end,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [atcs_pkg::SlotW-1:0]    m_out_slot,
    output logic                          m_capture,
    output logic                          m_active,
    output logic                          m_last_decision,
    // configuration writes
    input  logic                          cfg_wr_en,
    input  logic [atcs_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [atcs_pkg::CfgDataW-1:0] cfg_wdata
);

    localparam int IdxW = $clog2(MAX_SLOTS);
    localparam int CmpW = ((IdxW > atcs_pkg::SlotW) ? IdxW : atcs_pkg::SlotW) + 1;

    // configuration registers
    logic [atcs_pkg::CntW-1:0]     budget_reg;
    logic [atcs_pkg::CntW-1:0]     limit_reg;
    logic [atcs_pkg::CfgDataW-1:0] weight_reg;
    logic [atcs_pkg::GainW-1:0]    gain_reg;

    // per-slot state
    logic [atcs_pkg::PrioW-1:0]  prio_mem [MAX_SLOTS];
    logic [atcs_pkg::FrameW-1:0] cf_mem   [MAX_SLOTS];
    logic [atcs_pkg::UKeyW-1:0]  ukey_mem [MAX_SLOTS];
    logic [atcs_pkg::PKeyW-1:0]  pkey_mem [MAX_SLOTS];
    logic [MAX_SLOTS-1:0]        mask_reg;
    logic [MAX_SLOTS-1:0]        ever_reg;
    logic [MAX_SLOTS-1:0]        prev_act_reg;

    // frame bookkeeping
    logic [atcs_pkg::FrameW-1:0]   frame_reg;
    logic [atcs_pkg::FrameW-1:0]   cur_reg;
    logic [atcs_pkg::CfgDataW-1:0] warm_left_reg;

    // sequencer and datapath
    atcs_pkg::state_t            state_reg;
    atcs_pkg::state_t            state_next;
    logic [IdxW-1:0]             idx_reg;
    logic [atcs_pkg::AgeW-1:0]   age_reg;
    logic [atcs_pkg::PrioW-1:0]  prio_reg;
    logic [atcs_pkg::FacW-1:0]   fac_reg;
    logic [MAX_SLOTS-1:0]        cap_reg;
    logic [MAX_SLOTS-1:0]        act_reg;

    // output register
    logic                        m_valid_reg;
    logic [atcs_pkg::SlotW-1:0]  m_slot_reg;
    logic                        m_cap_reg;
    logic                        m_act_reg;
    logic                        m_last_reg;

    // item decode
    logic                 accept;
    logic                 in_range;
    logic [IdxW-1:0]      slot_idx;
    logic [MAX_SLOTS-1:0] slot_bit;
    logic [MAX_SLOTS-1:0] mask_after;
    logic                 warm_active;

    // shared multiplier
    logic [atcs_pkg::PrioW-1:0] mul_a;
    logic [atcs_pkg::FacW-1:0]  mul_b;
    logic [atcs_pkg::UKeyW-1:0] mul_prod;

    // age of the current slot
    logic [atcs_pkg::FrameW-1:0] frame_diff;
    logic [atcs_pkg::AgeW-1:0]   age_now;

    logic                 idx_last;
    logic [MAX_SLOTS-1:0] mask_hi;
    logic                 emit_hit;
    logic                 out_free;
    logic                 emit_step;
    logic                 emit_load;

    // ranking unit
    atcs_pkg::rank_ctrl_t       rank_ctrl;
    atcs_pkg::rank_stat_t       rank_stat;
    logic [IdxW-1:0]            rank_idx;
    logic [atcs_pkg::UKeyW-1:0] rank_key;
    logic [MAX_SLOTS-1:0]       rank_sel;
    logic [atcs_pkg::CntW-1:0]  budget_k;
    logic [atcs_pkg::CntW-1:0]  limit_k;

    // ------------------------------------------------------------------
    // item decode
    // ------------------------------------------------------------------
    assign s_ready  = (state_reg == atcs_pkg::ST_IDLE);
    assign accept   = s_valid & s_ready;
    assign in_range = (CmpW'(s_slot) < CmpW'(MAX_SLOTS));
    assign slot_idx = IdxW'(s_slot);
    assign slot_bit = in_range ? (MAX_SLOTS'(1) << slot_idx) : '0;

    // registration after this item is applied
    assign mask_after  = s_action ? (mask_reg & ~slot_bit) : (mask_reg | slot_bit);
    assign warm_active = (warm_left_reg != '0);

    // zero budget or limit acts as one
    assign budget_k = (budget_reg == '0) ? atcs_pkg::CntW'(1) : budget_reg;
    assign limit_k  = (limit_reg == '0) ? atcs_pkg::CntW'(1) : limit_reg;

    // ------------------------------------------------------------------
    // shared multiplier: weight*age, priority*factor, priority*gain
    // ------------------------------------------------------------------
    always_comb begin
        mul_a = prio_reg;
        mul_b = atcs_pkg::FacW'(gain_reg);
        case (state_reg)
            atcs_pkg::ST_FAC: begin
                mul_a = atcs_pkg::PrioW'(weight_reg);
                mul_b = atcs_pkg::FacW'(age_reg);
            end
            atcs_pkg::ST_UKEY: begin
                mul_b = fac_reg;
            end
            default: begin
                mul_b = atcs_pkg::FacW'(gain_reg);
            end
        endcase
    end

    assign mul_prod = atcs_pkg::UKeyW'(mul_a) * atcs_pkg::UKeyW'(mul_b);

    // frames since last capture, saturated; never captured uses a fixed age
    assign frame_diff = cur_reg - cf_mem[idx_reg];
    always_comb begin
        if (!ever_reg[idx_reg]) begin
            age_now = atcs_pkg::AgeW'(atcs_pkg::NeverCapturedAge);
        end else if (|frame_diff[atcs_pkg::FrameW-1:atcs_pkg::AgeW]) begin
            age_now = atcs_pkg::AgeW'(atcs_pkg::AgeSat);
        end else begin
            age_now = frame_diff[atcs_pkg::AgeW-1:0];
        end
    end

    assign idx_last = (idx_reg == IdxW'(MAX_SLOTS - 1));

    // emit walk: skip unregistered slots, wait when the output is full
    assign mask_hi   = mask_reg >> idx_reg;
    assign emit_hit  = mask_reg[idx_reg];
    assign out_free  = ~m_valid_reg | m_ready;
    assign emit_step = ~emit_hit | out_free;
    assign emit_load = (state_reg == atcs_pkg::ST_EMIT) & emit_hit & out_free;

    // ------------------------------------------------------------------
    // ranking unit, used once for capture and once for activity
    // ------------------------------------------------------------------
    assign rank_ctrl.start = ((state_reg == atcs_pkg::ST_PKEY) & idx_last)
                             | ((state_reg == atcs_pkg::ST_RANK_CAP) & rank_stat.done);
    assign rank_ctrl.k     = (state_reg == atcs_pkg::ST_PKEY) ? budget_k : limit_k;
    assign rank_key        = (state_reg == atcs_pkg::ST_RANK_CAP) ? ukey_mem[rank_idx]
                             : atcs_pkg::UKeyW'(pkey_mem[rank_idx]);

    atcs_rank #(
        .SLOTS (MAX_SLOTS),
        .KEY_W (atcs_pkg::UKeyW)
    ) u_rank (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (rank_ctrl),
        .cand_mask (mask_reg),
        .key_idx   (rank_idx),
        .key_data  (rank_key),
        .stat      (rank_stat),
        .sel_mask  (rank_sel)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= atcs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            atcs_pkg::ST_IDLE: begin
                if (accept && s_frame_end) begin
                    state_next = warm_active ? atcs_pkg::ST_COMMIT : atcs_pkg::ST_AGE;
                end
            end
            atcs_pkg::ST_AGE:  state_next = atcs_pkg::ST_FAC;
            atcs_pkg::ST_FAC:  state_next = atcs_pkg::ST_UKEY;
            atcs_pkg::ST_UKEY: state_next = atcs_pkg::ST_PKEY;
            atcs_pkg::ST_PKEY: begin
                state_next = idx_last ? atcs_pkg::ST_RANK_CAP : atcs_pkg::ST_AGE;
            end
            atcs_pkg::ST_RANK_CAP: begin
                if (rank_stat.done) begin
                    state_next = atcs_pkg::ST_RANK_ACT;
                end
            end
            atcs_pkg::ST_RANK_ACT: begin
                if (rank_stat.done) begin
                    state_next = atcs_pkg::ST_COMMIT;
                end
            end
            atcs_pkg::ST_COMMIT: state_next = atcs_pkg::ST_EMIT;
            atcs_pkg::ST_EMIT: begin
                if (emit_step && idx_last) begin
                    state_next = atcs_pkg::ST_IDLE;
                end
            end
            default: state_next = atcs_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // configuration, registration and frame state
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            budget_reg    <= atcs_pkg::BudgetRst;
            limit_reg     <= atcs_pkg::LimitRst;
            weight_reg    <= atcs_pkg::WeightRst;
            gain_reg      <= atcs_pkg::GainRst;
            warm_left_reg <= atcs_pkg::WarmupRst;
            mask_reg      <= '0;
            ever_reg      <= '0;
            prev_act_reg  <= '0;
            frame_reg     <= '0;
            idx_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (atcs_pkg::cfg_idx_t'(cfg_index))
                    atcs_pkg::CFG_CAPTURE_BUDGET:  budget_reg <= cfg_wdata[atcs_pkg::CntW-1:0];
                    atcs_pkg::CFG_ACTIVE_LIMIT:    limit_reg  <= cfg_wdata[atcs_pkg::CntW-1:0];
                    atcs_pkg::CFG_AGING_WEIGHT:    weight_reg <= cfg_wdata;
                    atcs_pkg::CFG_HYSTERESIS_GAIN: gain_reg   <= cfg_wdata;
                    // a warmup write restarts the warmup count
                    atcs_pkg::CFG_WARMUP_FRAMES:   warm_left_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            if (accept) begin
                mask_reg <= mask_after;
                if (s_action) begin
                    // unregister drops the slot's history too
                    ever_reg     <= ever_reg & ~slot_bit;
                    prev_act_reg <= prev_act_reg & ~slot_bit;
                end
                if (s_frame_end) begin
                    frame_reg <= frame_reg + atcs_pkg::FrameW'(1);
                    idx_reg   <= '0;
                    if (warm_active) begin
                        warm_left_reg <= warm_left_reg - atcs_pkg::CfgDataW'(1);
                    end
                end
            end

            case (state_reg)
                atcs_pkg::ST_PKEY: begin
                    idx_reg <= idx_reg + IdxW'(1);
                end
                atcs_pkg::ST_COMMIT: begin
                    ever_reg     <= ever_reg | cap_reg;
                    prev_act_reg <= act_reg;
                    idx_reg      <= '0;
                end
                atcs_pkg::ST_EMIT: begin
                    if (emit_step) begin
                        idx_reg <= idx_reg + IdxW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // payload storage and key build
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (accept && in_range && !s_action) begin
            prio_mem[slot_idx] <= s_priority_req;
        end
        if (accept && s_frame_end) begin
            cur_reg <= frame_reg;
            // warmup captures and activates every registered slot
            if (warm_active) begin
                cap_reg <= mask_after;
                act_reg <= mask_after;
            end
        end

        case (state_reg)
            atcs_pkg::ST_AGE: begin
                age_reg  <= age_now;
                prio_reg <= prio_mem[idx_reg];
            end
            atcs_pkg::ST_FAC: begin
                // factor = 1.0 + weight*age, Q14.4
                fac_reg <= atcs_pkg::FacW'(mul_prod) + atcs_pkg::FacW'(atcs_pkg::FacOne);
            end
            atcs_pkg::ST_UKEY: begin
                ukey_mem[idx_reg] <= mul_prod;
            end
            atcs_pkg::ST_PKEY: begin
                // previously active slots get the hysteresis gain, others 1.0 in Q2.6
                pkey_mem[idx_reg] <= prev_act_reg[idx_reg]
                    ? atcs_pkg::PKeyW'(mul_prod)
                    : atcs_pkg::PKeyW'({prio_reg, atcs_pkg::GainShift'(0)});
            end
            atcs_pkg::ST_RANK_CAP: begin
                if (rank_stat.done) begin
                    cap_reg <= rank_sel;
                end
            end
            atcs_pkg::ST_RANK_ACT: begin
                if (rank_stat.done) begin
                    act_reg <= rank_sel;
                end
            end
            default: ;
        endcase
    end

    // captured slots record the closing frame
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
            if ((state_reg == atcs_pkg::ST_COMMIT) && cap_reg[i]) begin
                cf_mem[i] <= cur_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_load) begin
            m_slot_reg <= atcs_pkg::SlotW'(idx_reg);
            m_cap_reg  <= cap_reg[idx_reg];
            m_act_reg  <= act_reg[idx_reg];
            // last when no registered slot lies above this one
            m_last_reg <= ~|mask_hi[MAX_SLOTS-1:1];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_slot      = m_slot_reg;
    assign m_capture       = m_cap_reg;
    assign m_active        = m_act_reg;
    assign m_last_decision = m_last_reg;

endmodule

// ===== rtl/core/atcs_rank.sv =====
// iterative top-k selector: repeated max extraction over a key table
// depends on atcs_pkg; keys are read one per cycle from the caller's storage

module atcs_rank #(
    parameter int SLOTS = atcs_pkg::MaxSlots,
    parameter int KEY_W = atcs_pkg::UKeyW
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  atcs_pkg::rank_ctrl_t   ctrl,
    input  logic [SLOTS-1:0]       cand_mask,
    output logic [$clog2(SLOTS)-1:0] key_idx,
    input  logic [KEY_W-1:0]       key_data,
    output atcs_pkg::rank_stat_t   stat,
    output logic [SLOTS-1:0]       sel_mask
);

    localparam int IdxW = $clog2(SLOTS);

    logic                      busy_reg;
    logic                      done_reg;
    logic [IdxW-1:0]           scan_reg;
    logic                      best_valid_reg;
    logic [KEY_W-1:0]          best_key_reg;
    logic [IdxW-1:0]           best_idx_reg;
    logic [atcs_pkg::CntW-1:0] count_reg;
    logic [atcs_pkg::CntW-1:0] k_reg;
    logic [SLOTS-1:0]          sel_reg;

    logic            take;
    logic            pass_valid;
    logic [IdxW-1:0] pass_idx;
    logic            pass_end;
    logic            finish;

    // strict compare while scanning upward keeps ties on the lower slot
    assign take = cand_mask[scan_reg] & ~sel_reg[scan_reg]
                  & (~best_valid_reg | (key_data > best_key_reg));
    assign pass_valid = take | best_valid_reg;
    assign pass_idx   = take ? scan_reg : best_idx_reg;
    assign pass_end   = (scan_reg == IdxW'(SLOTS - 1));
    assign finish     = busy_reg & pass_end
                        & (~pass_valid | ((count_reg + atcs_pkg::CntW'(1)) == k_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            done_reg       <= 1'b0;
            scan_reg       <= '0;
            best_valid_reg <= 1'b0;
            count_reg      <= '0;
            sel_reg        <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg       <= 1'b1;
                scan_reg       <= '0;
                best_valid_reg <= 1'b0;
                count_reg      <= '0;
                sel_reg        <= '0;
            end else if (busy_reg) begin
                if (pass_end) begin
                    scan_reg       <= '0;
                    best_valid_reg <= 1'b0;
                    if (pass_valid) begin
                        sel_reg[pass_idx] <= 1'b1;
                        count_reg         <= count_reg + atcs_pkg::CntW'(1);
                    end
                    if (finish) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end else begin
                    scan_reg <= scan_reg + IdxW'(1);
                    if (take) begin
                        best_valid_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // key and index of the running best, and the k of the run, payload only
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            k_reg <= ctrl.k;
        end
        if (take) begin
            best_key_reg <= key_data;
            best_idx_reg <= scan_reg;
        end
    end

    assign key_idx   = scan_reg;
    assign sel_mask  = sel_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== rtl/core/atcs_checker.sv =====
// port-level checker for the aging top-k capture scheduler, bound to the top
// depends on atcs_pkg and assert_macros.svh

`include "assert_macros.svh"

module atcs_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          s_frame_end,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [atcs_pkg::SlotW-1:0]    m_out_slot,
    input logic                          m_capture,
    input logic                          m_active,
    input logic                          m_last_decision
);

    logic [atcs_pkg::SlotW+2:0] m_payload;

    assign m_payload = {m_out_slot, m_capture, m_active, m_last_decision};

    // a stalled result holds its payload
    `AST_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload))

    // a frame end starts the frame processing and blocks the input
    `AST_NEXT(a_fend_busy, aclk, aresetn, s_valid && s_ready && s_frame_end, !s_ready)

    // a plain sample leaves the input ready
    `AST_NEXT(a_sample_fast, aclk, aresetn, s_valid && s_ready && !s_frame_end, s_ready)

    // results are only loaded while the input side is busy
    `AST_SAME(a_load_busy, aclk, aresetn, $rose(m_valid), $past(!s_ready))

endmodule

bind aging_topk_capture_scheduler_unit atcs_checker u_atcs_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_frame_end     (s_frame_end),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_out_slot      (m_out_slot),
    .m_capture       (m_capture),
    .m_active        (m_active),
    .m_last_decision (m_last_decision)
);
